### hw/rtl/key_matrix_debounce_press_detect_macros.svh
// Assertion macros used by the press walker of the key matrix debounce RTL.
`ifndef KEY_MATRIX_DEBOUNCE_PRESS_DETECT_MACROS_SVH
`define KEY_MATRIX_DEBOUNCE_PRESS_DETECT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KMD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define KMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/kmd_pkg.sv
// Package with the shared types and constants of the key matrix debounce block.
package kmd_pkg;

   localparam int KEY_BITS  = 64;
   localparam int KEY_NUM_W = 6;
   localparam int COUNT_W   = 8;
   localparam int DIM_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT          = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT          = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_THRESHOLD = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   // Command from the debounce logic to the press walker.
   typedef struct packed {
      logic                start;
      logic [KEY_BITS-1:0] rising;
      logic [KEY_BITS-1:0] in_use;
   } walk_cmd_type;

endpackage

### hw/rtl/key_matrix_debounce_press_detect.sv
// Top level of the key matrix debounce and press detection block.
//
//   channel | ports                              | direction | handshake
//   --------+------------------------------------+-----------+---------------------
//   req     | req_pressed_bits                   | in        | req_valid / req_stall
//   rsp     | rsp_key_number, rsp_last           | out       | rsp_valid / rsp_stall
//   csr     | csr_index, csr_wdata               | in        | csr_valid / csr_ready
//
// A scan transfer updates the debounce state at the edge that accepts it. If it confirms
// new presses, the walker tests one key bit per cycle, lowest first, except while rsp_stall
// holds the result register, and req_stall stays high until the walker has tested the bit
// of the highest new press; the final result may still wait in the result register while
// the next scan is taken. Synchronous reset clears the debounce state and the valid flag of
// the result register and restores the register defaults; there is no clearing pass.
module key_matrix_debounce_press_detect #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [kmd_pkg::KEY_BITS-1:0]        req_pressed_bits,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [kmd_pkg::KEY_NUM_W-1:0]       rsp_key_number,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kmd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [kmd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration registers, reset to a full eight by eight matrix and a
   // threshold of three.
   logic [kmd_pkg::DIM_W-1:0]   rows_ff, rows_in;
   logic [kmd_pkg::DIM_W-1:0]   cols_ff, cols_in;
   logic [kmd_pkg::COUNT_W-1:0] thresh_ff, thresh_in;

   logic [kmd_pkg::DIM_W-1:0]   eff_rows;
   logic [kmd_pkg::DIM_W-1:0]   eff_cols;
   logic [kmd_pkg::KEY_BITS-1:0] in_use;
   logic                         scan_accept;
   logic                         walk_busy;
   kmd_pkg::walk_cmd_type        walk_cmd;

   // The register port never pushes back; the user must write only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_comb begin
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      thresh_in = thresh_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            kmd_pkg::CSR_ROW_COUNT:          rows_in   = csr_wdata[kmd_pkg::DIM_W-1:0];
            kmd_pkg::CSR_COL_COUNT:          cols_in   = csr_wdata[kmd_pkg::DIM_W-1:0];
            kmd_pkg::CSR_DEBOUNCE_THRESHOLD: thresh_in = csr_wdata;
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= 4'd8;
         cols_ff   <= 4'd8;
         thresh_ff <= 8'd3;
      end else begin
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         thresh_ff <= thresh_in;
      end
   end

   // Row and column counts above the matrix size act as the full size. A key
   // takes part only when both its row and its column are in use; bit
   // row*8+col holds the key at that row and column.
   always_comb begin
      eff_rows = (rows_ff > kmd_pkg::DIM_W'(MAX_ROWS)) ? kmd_pkg::DIM_W'(MAX_ROWS) : rows_ff;
      eff_cols = (cols_ff > kmd_pkg::DIM_W'(MAX_COLS)) ? kmd_pkg::DIM_W'(MAX_COLS) : cols_ff;
      for (int i = 0; i < kmd_pkg::KEY_BITS; i++) begin
         in_use[i] = (kmd_pkg::DIM_W'(i / 8) < eff_rows) &&
                     (kmd_pkg::DIM_W'(i % 8) < eff_cols);
      end
   end

   // A scan is held off while the walker still lists the previous presses.
   assign req_stall   = walk_busy;
   assign scan_accept = req_valid && !req_stall;

   kmd_debounce u_debounce (
      .clock       (clock),
      .reset       (reset),
      .scan_accept (scan_accept),
      .scan_bits   (req_pressed_bits),
      .in_use      (in_use),
      .threshold   (thresh_ff),
      .walk_cmd    (walk_cmd)
   );

   kmd_walker u_walker (
      .clock          (clock),
      .reset          (reset),
      .walk_cmd       (walk_cmd),
      .busy           (walk_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_key_number (rsp_key_number),
      .rsp_last       (rsp_last)
   );

endmodule

### hw/rtl/kmd_debounce.sv
// Debounce state and the decision taken on each accepted scan.
module kmd_debounce (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              scan_accept,
   input  logic [kmd_pkg::KEY_BITS-1:0]      scan_bits,
   input  logic [kmd_pkg::KEY_BITS-1:0]      in_use,
   input  logic [kmd_pkg::COUNT_W-1:0]       threshold,
   output kmd_pkg::walk_cmd_type             walk_cmd
);

   logic [kmd_pkg::KEY_BITS-1:0] stable_ff, stable_in;
   logic [kmd_pkg::KEY_BITS-1:0] cand_ff, cand_in;
   logic                         active_ff, active_in;
   logic [kmd_pkg::COUNT_W-1:0]  count_ff, count_in;

   logic [kmd_pkg::KEY_BITS-1:0] scan_masked;
   logic [kmd_pkg::KEY_BITS-1:0] cand_masked;
   logic [kmd_pkg::KEY_BITS-1:0] stable_masked;
   logic [kmd_pkg::COUNT_W-1:0]  count_up;
   logic [kmd_pkg::COUNT_W-1:0]  count_down;

   always_comb begin
      scan_masked   = scan_bits & in_use;
      cand_masked   = cand_ff & in_use;
      stable_masked = stable_ff & in_use;
      count_up   = (count_ff == kmd_pkg::COUNT_MAX) ? count_ff : count_ff + 1'b1;
      count_down = (count_ff == '0) ? count_ff : count_ff - 1'b1;

      stable_in = stable_ff;
      cand_in   = cand_ff;
      active_in = active_ff;
      count_in  = count_ff;
      walk_cmd.start  = 1'b0;
      walk_cmd.rising = cand_masked & ~stable_masked;
      walk_cmd.in_use = in_use;

      if (scan_accept) begin
         if (!active_ff) begin
            // A scan that leaves the stable set opens a new candidate.
            if (scan_masked != stable_masked) begin
               active_in = 1'b1;
               cand_in   = scan_masked;
               count_in  = {{(kmd_pkg::COUNT_W-1){1'b0}}, 1'b1};
            end
         end else if (scan_masked == cand_masked) begin
            count_in = count_up;
            if (count_up > threshold) begin
               stable_in = cand_masked;
               count_in  = '0;
               active_in = 1'b0;
               walk_cmd.start = (walk_cmd.rising != '0);
            end
         end else begin
            count_in = count_down;
            if (count_down == '0) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= '0;
         cand_ff   <= '0;
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         stable_ff <= stable_in;
         cand_ff   <= cand_in;
         active_ff <= active_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/kmd_walker.sv
// Press walker: tests one key bit per cycle unless the result register is stalled, and loads the result register.
`include "key_matrix_debounce_press_detect_macros.svh"

module kmd_walker (
   input  logic                              clock,
   input  logic                              reset,
   input  kmd_pkg::walk_cmd_type             walk_cmd,
   output logic                              busy,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [kmd_pkg::KEY_NUM_W-1:0]     rsp_key_number,
   output logic                              rsp_last
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic                          state_ff, state_in;
   logic [kmd_pkg::KEY_BITS-1:0]  rising_ff, rising_in;
   logic [kmd_pkg::KEY_BITS-1:0]  use_ff, use_in;
   logic [kmd_pkg::KEY_NUM_W-1:0] num_ff, num_in;
   logic                          out_valid_ff, out_valid_in;
   logic [kmd_pkg::KEY_NUM_W-1:0] out_key_ff, out_key_in;
   logic                          out_last_ff, out_last_in;

   logic                           advance;
   logic                           hit;
   logic [kmd_pkg::KEY_BITS-2:0]   remain;

   always_comb begin
      advance = !out_valid_ff || !rsp_stall;
      remain  = rising_ff[kmd_pkg::KEY_BITS-1:1];
      hit     = (state_ff == ST_WALK) && advance && rising_ff[0];

      state_in     = state_ff;
      rising_in    = rising_ff;
      use_in       = use_ff;
      num_in       = num_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_key_in   = out_key_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (walk_cmd.start) begin
               state_in  = ST_WALK;
               rising_in = walk_cmd.rising;
               use_in    = walk_cmd.in_use;
               num_in    = '0;
            end
         end
         ST_WALK: begin
            if (advance) begin
               if (hit) begin
                  out_valid_in = 1'b1;
                  out_key_in   = num_ff;
                  out_last_in  = (remain == '0);
               end
               // Only keys in use take a number.
               num_in    = num_ff + {{(kmd_pkg::KEY_NUM_W-1){1'b0}}, use_ff[0]};
               rising_in = {1'b0, remain};
               use_in    = {1'b0, use_ff[kmd_pkg::KEY_BITS-1:1]};
               if (remain == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      rising_ff   <= rising_in;
      use_ff      <= use_in;
      num_ff      <= num_in;
      out_key_ff  <= out_key_in;
      out_last_ff <= out_last_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = out_valid_ff;
   assign rsp_key_number = out_key_ff;
   assign rsp_last       = out_last_ff;

   `KMD_ASSERT_SAME(a_start_only_idle, clock, reset, walk_cmd.start, state_ff == ST_IDLE, "walk started while busy")
   `KMD_ASSERT_SAME(a_walk_has_work, clock, reset, state_ff == ST_WALK, rising_ff != '0, "walking with no pending press")
   `KMD_ASSERT_NEXT(a_last_ends_walk, clock, reset, hit && (remain == '0), state_ff == ST_IDLE && rsp_valid && rsp_last, "final press did not end the walk")
   `KMD_ASSERT_NEXT(a_hit_loads_output, clock, reset, hit && (remain != '0), rsp_valid && !rsp_last, "press not loaded as a non-final result")

endmodule

### dv/key_matrix_debounce_press_detect_tb.sv
// Self-checking testbench for the key matrix debounce and press detection block.
module key_matrix_debounce_press_detect_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kmd_pkg::*;

   // Index three decodes to no register; a write there must leave every setting alone.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // Cycles without any transfer on any channel before the run is declared hung.
   // The slowest legitimate stretch is a press walk over all 64 bits plus a full
   // receiver stall, plus the settle pause below; this is many times that.
   localparam int WATCHDOG_LIMIT = 4000;

   // The press walker may still be running after a transfer, so this pause
   // separates the last result from any register write or the end of the run.
   localparam int SETTLE_CYCLES = 70;

   // Largest matrix dimension; larger register values saturate to it.
   localparam int DIM_MAX = 8;

   // One expected result: a newly pressed key and its end-of-group flag.
   typedef struct packed {
      logic [KEY_NUM_W-1:0] key_number;
      logic                 last;
   } key_press_t;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [KEY_BITS-1:0]   req_pressed_bits = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [KEY_NUM_W-1:0]  rsp_key_number;
   logic                  rsp_last;
   logic                  csr_valid        = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_wdata        = '0;

   // When set, neither side inserts idle cycles; the closing part of the run uses it.
   bit calm = 1'b0;
   int errors = 0;

   // Key presses predicted but not yet seen on the result channel, oldest first.
   key_press_t pending_presses[$];

   // Our own copy of the register settings, starting at their reset values.
   logic [DIM_W-1:0]   rows_reg      = 4'd8;
   logic [DIM_W-1:0]   cols_reg      = 4'd8;
   logic [COUNT_W-1:0] threshold_reg = 8'd3;

   // Our own copy of the debounce state, starting with every key released.
   logic [KEY_BITS-1:0] settled_keys = '0;
   logic [KEY_BITS-1:0] held_keys    = '0;
   logic                holding      = 1'b0;
   logic [COUNT_W-1:0]  agreement    = '0;

   // Receiver backpressure bookkeeping.
   int stall_left = 0;
   int open_left  = 0;

   always #1 clock = ~clock;

   key_matrix_debounce_press_detect u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pressed_bits (req_pressed_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_number   (rsp_key_number),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Effective row and column counts: values above the matrix size saturate.
   function automatic int active_rows();
      return (rows_reg > DIM_MAX) ? DIM_MAX : int'(rows_reg);
   endfunction

   function automatic int active_cols();
      return (cols_reg > DIM_MAX) ? DIM_MAX : int'(cols_reg);
   endfunction

   // Bits of the scan word that belong to rows and columns in use. Scan bit
   // positions always use a stride of eight, whatever the column count is.
   function automatic logic [KEY_BITS-1:0] keys_in_use();
      logic [KEY_BITS-1:0] m;
      m = '0;
      for (int r = 0; r < active_rows(); r++) begin
         for (int c = 0; c < active_cols(); c++) begin
            m[r*DIM_MAX+c] = 1'b1;
         end
      end
      return m;
   endfunction

   // Advances the debounce state by one accepted scan and queues every key
   // press that the scan causes, lowest key number first.
   function automatic void predict_scan(input logic [KEY_BITS-1:0] bits);
      logic [KEY_BITS-1:0] mask;
      logic [KEY_BITS-1:0] scan;
      logic [KEY_BITS-1:0] rising;
      int                  total;
      int                  seen;
      key_press_t          p;
      mask = keys_in_use();
      scan = bits & mask;
      if (!holding) begin
         // With no candidate, any change from the settled set opens one.
         if (scan != (settled_keys & mask)) begin
            holding   = 1'b1;
            held_keys = scan;
            agreement = 8'd1;
         end
      end else if (scan == (held_keys & mask)) begin
         // Agreement saturates, so a threshold of 255 can never be exceeded.
         if (agreement != COUNT_MAX) begin
            agreement++;
         end
         if (agreement > threshold_reg) begin
            rising = held_keys & mask & ~settled_keys;
            total  = $countones(rising);
            seen   = 0;
            for (int r = 0; r < active_rows(); r++) begin
               for (int c = 0; c < active_cols(); c++) begin
                  if (rising[r*DIM_MAX+c]) begin
                     seen++;
                     p.key_number = KEY_NUM_W'(r * active_cols() + c);
                     p.last       = (seen == total);
                     pending_presses.push_back(p);
                  end
               end
            end
            settled_keys = held_keys & mask;
            agreement    = '0;
            holding      = 1'b0;
         end
      end else begin
         // A disagreeing scan wears the count down; the candidate stays until the count reaches zero.
         if (agreement != '0) begin
            agreement--;
         end
         if (agreement == '0) begin
            holding = 1'b0;
         end
      end
   endfunction

   // Offers one scan, holds it steady until the block takes it, and then
   // updates the prediction. Valid is left high so that a following scan can
   // go out back to back; it is lowered only where a gap is wanted.
   task automatic send_scan(input logic [KEY_BITS-1:0] bits);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pressed_bits <= bits;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_scan(bits);
   endtask

   // Stops offering scans and waits until every predicted press has been
   // seen, then lets the press walker run out before anything else happens.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_presses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write transfer; our copy of the setting follows it.
   task automatic write_register(input logic [CSR_IDX_W-1:0]  idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ROW_COUNT: begin
            rows_reg = value[DIM_W-1:0];
         end
         CSR_COL_COUNT: begin
            cols_reg = value[DIM_W-1:0];
         end
         CSR_DEBOUNCE_THRESHOLD: begin
            threshold_reg = value;
         end
         default: begin
         end
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // A key pattern of varied density, sometimes close to the settled set so
   // that both releases and fresh presses show up.
   function automatic logic [KEY_BITS-1:0] random_keys();
      logic [KEY_BITS-1:0] k;
      case ($urandom_range(0, 4))
         0: begin
            k = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         end
         1: begin
            k = {$urandom, $urandom};
         end
         2: begin
            k = {$urandom, $urandom} | {$urandom, $urandom};
         end
         3: begin
            k = settled_keys ^ (64'd1 << $urandom_range(0, 63))
                             ^ (64'd1 << $urandom_range(0, 63));
         end
         default: begin
            k = settled_keys & {$urandom, $urandom};
         end
      endcase
      return k;
   endfunction

   // One random phase: fresh settings written while idle, then mostly runs of
   // identical scans long enough to pass the threshold, with bounces and
   // unrelated noise mixed in. Bits outside the matrix in use carry junk.
   task automatic run_phase(input int scans);
      logic [KEY_BITS-1:0] target;
      logic [KEY_BITS-1:0] bits;
      logic [COUNT_W-1:0]  thr;
      int                  limit;
      int                  sent;
      int                  reps;
      drain();
      if ($urandom_range(0, 9) == 0) begin
         write_register(CSR_ROW_COUNT, {4'($urandom), 4'($urandom)});
      end else begin
         write_register(CSR_ROW_COUNT, {4'($urandom), 4'($urandom_range(1, 8))});
      end
      if ($urandom_range(0, 9) == 0) begin
         write_register(CSR_COL_COUNT, {4'($urandom), 4'($urandom)});
      end else begin
         write_register(CSR_COL_COUNT, {4'($urandom), 4'($urandom_range(1, 8))});
      end
      case ($urandom_range(0, 19))
         0:       thr = 8'd254;
         1:       thr = COUNT_MAX;
         2, 3:    thr = 8'($urandom_range(6, 12));
         default: thr = 8'($urandom_range(0, 4));
      endcase
      write_register(CSR_DEBOUNCE_THRESHOLD, thr);
      // Moderate thresholds get a phase long enough for at least one acceptance.
      limit = scans;
      if (thr <= 8'd12 && limit < int'(thr) + 3) begin
         limit = int'(thr) + 3;
      end
      sent = 0;
      while (sent < limit) begin
         target = random_keys();
         reps   = int'(threshold_reg) + 2 + $urandom_range(0, 2);
         for (int i = 0; i < reps && sent < limit; i++) begin
            case ($urandom_range(0, 11))
               0: begin
                  bits = {$urandom, $urandom};
               end
               1: begin
                  bits = target ^ (64'd1 << $urandom_range(0, 63));
               end
               default: begin
                  bits = target;
               end
            endcase
            bits = bits | ({$urandom, $urandom} & ~keys_in_use());
            send_scan(bits);
            sent++;
         end
      end
   endtask

   // Reset settings with every key held: the largest possible burst of 64
   // presses, keys 0 through 63, once the default threshold of three is passed.
   task automatic test_reset_defaults();
      repeat (5) send_scan('1);
   endtask

   // Threshold zero: releasing everything is accepted without any result,
   // then the lowest and highest keys are pressed one after the other.
   task automatic test_single_keys();
      drain();
      write_register(CSR_DEBOUNCE_THRESHOLD, 8'd0);
      repeat (2) send_scan('0);
      repeat (2) send_scan(64'h0000_0000_0000_0001);
      repeat (2) send_scan(64'h8000_0000_0000_0001);
   endtask

   // A bounce in the middle of agreement only lowers the count and keeps the
   // candidate; afterwards a lone disagreeing scan drops a fresh candidate.
   task automatic test_bounce();
      logic [KEY_BITS-1:0] a;
      a = 64'h0000_0012_0000_0000;
      drain();
      write_register(CSR_DEBOUNCE_THRESHOLD, 8'd2);
      send_scan(a);
      send_scan(a);
      send_scan(a | 64'h0000_0000_0010_0000);
      send_scan(a);
      send_scan(a);
      send_scan(64'h0000_0000_0000_00FF);
      send_scan(64'h0000_0000_0000_FF00);
   endtask

   // Zero rows leave no key in use; an oversized row count saturates while a
   // narrow column count renumbers the keys; a write to the unused index
   // changes nothing; zero columns again leave no key in use.
   task automatic test_dimensions();
      drain();
      write_register(CSR_ROW_COUNT, {4'hA, 4'd0});
      send_scan('1);
      drain();
      write_register(CSR_ROW_COUNT, {4'h5, 4'd15});
      write_register(CSR_COL_COUNT, {4'hC, 4'd3});
      write_register(CSR_DEBOUNCE_THRESHOLD, 8'd0);
      repeat (2) send_scan('1);
      drain();
      write_register(CSR_UNUSED, 8'hFF);
      write_register(CSR_COL_COUNT, {4'hF, 4'd0});
      send_scan('1);
   endtask

   // A threshold of 255 can never be exceeded, yet disagreeing scans still
   // wear the candidate down and drop it, after which a new one can form.
   task automatic test_threshold_max();
      logic [KEY_BITS-1:0] x;
      x = 64'hFFFF_0000_FFFF_0000;
      drain();
      write_register(CSR_ROW_COUNT, {4'h3, 4'd8});
      write_register(CSR_COL_COUNT, {4'h6, 4'd9});
      write_register(CSR_DEBOUNCE_THRESHOLD, COUNT_MAX);
      repeat (2) send_scan(x);
      repeat (2) send_scan(~x);
      send_scan(x);
   endtask

   // The bulk of the random traffic, with idling on both sides.
   task automatic test_random_phases();
      repeat (10) run_phase($urandom_range(10, 18));
   endtask

   // The closing part: full rate on both channels, no idling at all.
   task automatic test_back_to_back();
      drain();
      calm = 1'b1;
      repeat (2) run_phase(12);
   endtask

   // Receiver backpressure: random stall bursts alternate with open stretches,
   // so stalls land on every part of a press walk.
   always @(posedge clock) begin : rsp_backpressure
      if (calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (open_left > 0) begin
         open_left--;
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_stall <= 1'b1;
      end else begin
         open_left = $urandom_range(1, 30) - 1;
         rsp_stall <= 1'b0;
      end
   end

   // Every result transfer is checked against the oldest predicted press.
   always @(posedge clock) begin : press_checker
      key_press_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_presses.size() == 0) begin
            $error("unexpected result: key_number %0d last %0b", rsp_key_number, rsp_last);
            errors++;
         end else begin
            want = pending_presses.pop_front();
            if (rsp_key_number !== want.key_number) begin
               $error("key_number: expected %0d, actual %0d", want.key_number,
                      rsp_key_number);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // Watchdog: ends the run when no transfer of any kind has happened for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Test sequence: one reset, the directed cases, random traffic, then a
   // final drain before the verdict.
   initial begin : main
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_single_keys();
      test_bounce();
      test_dimensions();
      test_threshold_max();
      test_random_phases();
      test_back_to_back();
      drain();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
